// ===== hdl/depth_roi_median_locator_macros.svh =====
// Assertion macros used by the depth ROI median locator back end.
`ifndef DEPTH_ROI_MEDIAN_LOCATOR_MACROS_SVH
`define DEPTH_ROI_MEDIAN_LOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DRML_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DRML_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DRML_ASSERT(lbl, prop, msg)
`define DRML_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/drml_pkg.sv =====
// Shared types and constants of the depth ROI median locator.
`default_nettype none
package drml_pkg;
    localparam int DEPTH_W    = 16;
    localparam int COL_IN_W   = 10;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND        = 3'd4;

    localparam logic [13:0] PRINCIPAL_X_RESET = 14'd5120;
    localparam logic [13:0] FOCAL_X_RESET     = 14'd8400;
    localparam logic [15:0] MIN_DEPTH_RESET   = 16'd10;
    localparam logic [15:0] MAX_DEPTH_RESET   = 16'd6000;
    localparam logic [9:0]  BAND_RESET        = 10'd120;

    typedef struct packed {
        logic                keep;
        logic                last;
        logic [COL_IN_W-1:0] col;
        logic [DEPTH_W-1:0]  depth;
    } pix_t;

    typedef enum logic [3:0] {
        B_FILL,
        B_START,
        B_MED,
        B_BAND,
        B_ZS,
        B_MUL,
        B_DIVS,
        B_DIVW,
        B_OUT
    } back_state_t;
endpackage
`default_nettype wire

// ===== hdl/depth_roi_median_locator.sv =====
// Depth ROI median locator top level: configuration registers, front and back ends.
//
// Pixels of a region are accepted at one per cycle while the queue has room, and the
// kept ones are written into two MAX_POINTS-deep memories with one write and one
// registered read port (depth and column); no clearing pass is needed. After the last
// pixel the back end runs 16 counting passes for the first median, one pass for the
// band extent and up to 11 passes for the band median, each over the n kept pixels,
// then a multiply and a one-bit-per-cycle divide. A four-entry queue keeps taking
// pixels meanwhile; once it fills, the input stalls until the result is registered.
`default_nettype none
module depth_roi_median_locator #(
    parameter int MAX_POINTS  = 65536,
    parameter int COLUMN_BITS = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [drml_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [drml_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [drml_pkg::COL_IN_W-1:0]   pixel_column,
    input  wire logic [drml_pkg::DEPTH_W-1:0]    depth_raw_mm,
    input  wire logic                            last_pixel,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 found,
    output logic signed [16:0]                   person_x_mm,
    output logic [drml_pkg::DEPTH_W-1:0]         person_z_mm
);
    import drml_pkg::*;

    logic [13:0]  principal_x_reg;
    logic [13:0]  focal_x_reg;
    logic [15:0]  min_depth_reg;
    logic [15:0]  max_depth_reg;
    logic [9:0]   band_reg;
    pix_t         q_data;
    logic         q_valid;
    logic         q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            principal_x_reg <= PRINCIPAL_X_RESET;
            focal_x_reg     <= FOCAL_X_RESET;
            min_depth_reg   <= MIN_DEPTH_RESET;
            max_depth_reg   <= MAX_DEPTH_RESET;
            band_reg        <= BAND_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PRINCIPAL_X: principal_x_reg <= cfg_data[13:0];
                REG_FOCAL_X:     focal_x_reg     <= cfg_data[13:0];
                REG_MIN_DEPTH:   min_depth_reg   <= cfg_data;
                REG_MAX_DEPTH:   max_depth_reg   <= cfg_data;
                REG_BAND:        band_reg        <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    drml_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_column (pixel_column),
        .depth_raw_mm (depth_raw_mm),
        .last_pixel   (last_pixel),
        .min_depth    (min_depth_reg),
        .max_depth    (max_depth_reg),
        .q_data       (q_data),
        .q_valid      (q_valid),
        .q_pop        (q_pop)
    );

    drml_back #(.MAX_POINTS(MAX_POINTS), .COLUMN_BITS(COLUMN_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_data),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .principal_x (principal_x_reg),
        .focal_x     (focal_x_reg),
        .band        (band_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .person_x_mm (person_x_mm),
        .person_z_mm (person_z_mm)
    );
endmodule
`default_nettype wire

// ===== hdl/drml_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module drml_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 65536,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/drml_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module drml_div #(
    parameter int N   = 35,
    parameter int DVW = 14
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N-1:0]   dividend,
    input  wire logic [DVW-1:0] divisor,
    output logic                done,
    output logic      [N-1:0]   quotient
);
    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVW-1:0]   rem_reg, rem_next;
    logic [DVW-1:0]   dvs_reg, dvs_next;
    logic [N-1:0]     quo_reg, quo_next;
    logic [DVW:0]     trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[N-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[N-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVW-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== hdl/drml_front.sv =====
// Front end: depth gating and the pixel queue toward the back end.
`default_nettype none
module drml_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [drml_pkg::COL_IN_W-1:0] pixel_column,
    input  wire logic [drml_pkg::DEPTH_W-1:0]  depth_raw_mm,
    input  wire logic                          last_pixel,
    input  wire logic [drml_pkg::DEPTH_W-1:0]  min_depth,
    input  wire logic [drml_pkg::DEPTH_W-1:0]  max_depth,
    output drml_pkg::pix_t                     q_data,
    output logic                               q_valid,
    input  wire logic                          q_pop
);
    import drml_pkg::*;

    pix_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              push;
    logic              keep;
    pix_t              entry;

    assign keep     = (depth_raw_mm >= min_depth) && (depth_raw_mm <= max_depth);
    assign in_stall = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall && (keep || last_pixel);
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem_reg[rptr_reg];

    always_comb
    begin
        entry.keep  = keep;
        entry.last  = last_pixel;
        entry.col   = pixel_column;
        entry.depth = depth_raw_mm;
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = q_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= entry;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/drml_back.sv =====
// Back end: point store, median searches, band extent and back-projection.
`default_nettype none
`include "depth_roi_median_locator_macros.svh"
module drml_back #(
    parameter int MAX_POINTS  = 65536,
    parameter int COLUMN_BITS = 10
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  drml_pkg::pix_t                    q_data,
    input  wire logic                         q_valid,
    output logic                              q_pop,
    input  wire logic [13:0]                  principal_x,
    input  wire logic [13:0]                  focal_x,
    input  wire logic [9:0]                   band,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              found,
    output logic signed [16:0]                person_x_mm,
    output logic [drml_pkg::DEPTH_W-1:0]      person_z_mm
);
    import drml_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = ((COLUMN_BITS + 4 > 14) ? COLUMN_BITS + 4 : 14) + 1;
    localparam int PW = DW + 16;

    back_state_t            state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          scan_cnt_reg, scan_cnt_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CW-1:0]          k_reg, k_next;
    logic [CW-1:0]          acc_reg, acc_next;
    logic [15:0]            slo_reg, slo_next;
    logic [15:0]            shi_reg, shi_next;
    logic [15:0]            plo_reg, plo_next;
    logic [15:0]            bhi_reg, bhi_next;
    logic [COLUMN_BITS-1:0] cmin_reg, cmin_next;
    logic [COLUMN_BITS-1:0] cmax_reg, cmax_next;
    logic [15:0]            z_reg, z_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic                   neg_reg, neg_next;
    logic                   res_found_reg, res_found_next;
    logic signed [16:0]     res_x_reg, res_x_next;
    logic                   found_reg, found_next;
    logic signed [16:0]     x_reg, x_next;
    logic [15:0]            zo_reg, zo_next;

    logic                   ram_we;
    logic [15:0]            rd_depth;
    logic [COLUMN_BITS-1:0] rd_col;
    logic [COLUMN_BITS-1:0] wr_col;
    logic [23:0]            col_wide;
    logic                   scanning;
    logic                   issue;
    logic                   pass_end;
    logic [16:0]            mid_sum;
    logic [15:0]            mid;
    logic [15:0]            upper;
    logic                   in_range;
    logic [15:0]            nlo, nhi;
    logic [16:0]            band_hi;
    logic [15:0]            band_lo;
    logic [DW-1:0]          diff;
    logic [DW-1:0]          mag;
    logic                   div_start;
    logic                   div_done;
    logic [PW-1:0]          quo;
    logic [13:0]            fx_eff;

    assign col_wide = {14'd0, q_data.col};
    assign wr_col   = col_wide[COLUMN_BITS-1:0];
    assign fx_eff   = (focal_x == 14'd0) ? 14'd1 : focal_x;

    drml_ram #(.WIDTH(16), .DEPTH(MAX_POINTS), .ADDR_BITS(AW)) u_depth_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (q_data.depth),
        .raddr (scan_cnt_reg[AW-1:0]),
        .rdata (rd_depth)
    );

    drml_ram #(.WIDTH(COLUMN_BITS), .DEPTH(MAX_POINTS), .ADDR_BITS(AW)) u_col_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_col),
        .raddr (scan_cnt_reg[AW-1:0]),
        .rdata (rd_col)
    );

    drml_div #(.N(PW), .DVW(14)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (fx_eff),
        .done     (div_done),
        .quotient (quo)
    );

    assign scanning = (state_reg == B_MED) || (state_reg == B_BAND) || (state_reg == B_ZS);
    assign issue    = scanning && (scan_cnt_reg < count_reg);
    assign pass_end = scanning && (scan_cnt_reg == count_reg) && !rd_valid_reg;
    assign mid_sum  = {1'b0, slo_reg} + {1'b0, shi_reg};
    assign mid      = mid_sum[16:1];
    assign upper    = (state_reg == B_BAND) ? bhi_reg : mid;
    assign in_range = rd_valid_reg && (rd_depth >= plo_reg) && (rd_depth <= upper);
    assign nlo      = (acc_reg > k_reg) ? slo_reg : mid + 16'd1;
    assign nhi      = (acc_reg > k_reg) ? mid : shi_reg;
    assign band_lo  = (nlo >= {6'd0, band}) ? nlo - {6'd0, band} : 16'd0;
    assign band_hi  = {1'b0, nlo} + {7'd0, band};
    assign diff     = DW'({({1'b0, cmin_reg} + {1'b0, cmax_reg}), 3'b000}) - DW'(principal_x);
    assign mag      = diff[DW-1] ? DW'(-diff) : diff;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_valid_next  = 1'b0;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        slo_next       = slo_reg;
        shi_next       = shi_reg;
        plo_next       = plo_reg;
        bhi_next       = bhi_reg;
        cmin_next      = cmin_reg;
        cmax_next      = cmax_reg;
        z_next         = z_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        res_found_next = res_found_reg;
        res_x_next     = res_x_reg;
        found_next     = found_reg;
        x_next         = x_reg;
        zo_next        = zo_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (scanning)
        begin
            if (issue)
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            rd_valid_next = issue;
            if (in_range)
            begin
                acc_next = acc_reg + 1'b1;
                if (state_reg == B_BAND)
                begin
                    if (rd_col < cmin_reg)
                    begin
                        cmin_next = rd_col;
                    end
                    if (rd_col > cmax_reg)
                    begin
                        cmax_next = rd_col;
                    end
                end
            end
        end

        unique case (state_reg)
            B_FILL:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_data.keep && (count_reg < CW'(MAX_POINTS)))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (q_data.last)
                    begin
                        state_next = B_START;
                    end
                end
            end
            B_START:
            begin
                scan_cnt_next = '0;
                acc_next      = '0;
                if (count_reg == '0)
                begin
                    res_found_next = 1'b0;
                    res_x_next     = '0;
                    z_next         = '0;
                    state_next     = B_OUT;
                end
                else
                begin
                    slo_next   = 16'd0;
                    shi_next   = 16'hFFFF;
                    plo_next   = 16'd0;
                    k_next     = count_reg >> 1;
                    state_next = B_MED;
                end
            end
            B_MED, B_ZS:
            begin
                if (pass_end)
                begin
                    slo_next      = nlo;
                    shi_next      = nhi;
                    scan_cnt_next = '0;
                    acc_next      = '0;
                    if (nlo == nhi)
                    begin
                        if (state_reg == B_MED)
                        begin
                            plo_next   = band_lo;
                            bhi_next   = band_hi[16] ? 16'hFFFF : band_hi[15:0];
                            cmin_next  = '1;
                            cmax_next  = '0;
                            state_next = B_BAND;
                        end
                        else
                        begin
                            z_next     = nlo;
                            state_next = B_MUL;
                        end
                    end
                end
            end
            B_BAND:
            begin
                if (pass_end)
                begin
                    k_next        = acc_reg >> 1;
                    slo_next      = plo_reg;
                    shi_next      = bhi_reg;
                    scan_cnt_next = '0;
                    acc_next      = '0;
                    if (plo_reg == bhi_reg)
                    begin
                        z_next     = plo_reg;
                        state_next = B_MUL;
                    end
                    else
                    begin
                        state_next = B_ZS;
                    end
                end
            end
            B_MUL:
            begin
                prod_next  = PW'(mag) * PW'(z_reg);
                neg_next   = diff[DW-1];
                state_next = B_DIVS;
            end
            B_DIVS:
            begin
                div_start  = 1'b1;
                state_next = B_DIVW;
            end
            B_DIVW:
            begin
                if (div_done)
                begin
                    res_found_next = 1'b1;
                    if (!neg_reg)
                    begin
                        res_x_next = (quo > PW'(65535)) ? 17'sd65535 : $signed({1'b0, quo[15:0]});
                    end
                    else
                    begin
                        res_x_next = (quo > PW'(65536)) ? -17'sd65536 : $signed(17'(-quo[16:0]));
                    end
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    x_next         = res_x_reg;
                    zo_next        = z_reg;
                    count_next     = '0;
                    state_next     = B_FILL;
                end
            end
            default:
            begin
                state_next = B_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_FILL;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        acc_reg       <= acc_next;
        slo_reg       <= slo_next;
        shi_reg       <= shi_next;
        plo_reg       <= plo_next;
        bhi_reg       <= bhi_next;
        cmin_reg      <= cmin_next;
        cmax_reg      <= cmax_next;
        z_reg         <= z_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        res_found_reg <= res_found_next;
        res_x_reg     <= res_x_next;
        found_reg     <= found_next;
        x_reg         <= x_next;
        zo_reg        <= zo_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign person_x_mm = x_reg;
    assign person_z_mm = zo_reg;

    `DRML_ASSERT(a_count_bound, count_reg <= CW'(MAX_POINTS), "kept count beyond store depth")
    `DRML_ASSERT(a_search_open, !(state_reg == B_MED || state_reg == B_ZS) || (slo_reg < shi_reg), "search interval collapsed while searching")
    `DRML_ASSERT(a_empty_zero, !(out_valid_reg && !found_reg) || (x_reg == 17'sd0 && zo_reg == 16'd0), "empty result carries nonzero fields")
    `DRML_ASSERT_NEXT(a_div_to_out, state_reg == B_DIVW && div_done, state_reg == B_OUT, "quotient not taken into result")
endmodule
`default_nettype wire
